### hdl/clr_pkg.sv
// ---------------------------------------------------------------------------
// clr_pkg: shared definitions of the coupled level relaxation block
// Field widths, register indexes, coefficient tables, the datapath command
// and status structures, and helpers that scale coefficients to fixed point.
// ---------------------------------------------------------------------------
package clr_pkg;

	localparam int FRAC_BITS_DEF = 15;
	localparam int NCH           = 6;

	localparam int LEVEL_W  = 16;
	localparam int LIMIT_W  = 8;
	localparam int GAIN_W   = 16;
	localparam int THR_W    = 18;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 18;
	localparam int CH_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MOMENTUM  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd1;

	localparam logic [GAIN_W-1:0] MOMENTUM_RST  = 16'd22938;
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 18'd328;

	// Coupling weights in tenths, indexed [source][target].
	localparam int COUPLING_TENTHS [NCH][NCH] = '{
		'{ 0, -3,  6,  4, -2,  3},
		'{-3,  0, -6, -5,  3,  4},
		'{ 3, -4,  0,  2, -3,  2},
		'{ 5, -7,  3,  0, -4,  5},
		'{-2,  2, -2, -3,  0,  2},
		'{ 3,  2,  2,  3,  1,  0}
	};

	// Per-chamber decay in hundredths.
	localparam int DECAY_HUND [NCH] = '{90, 93, 85, 97, 88, 94};

	typedef enum logic [1:0] {
		MUL_DECAY,
		MUL_COUPLE,
		MUL_MOMENT,
		MUL_REST
	} mul_op_t;

	typedef struct packed {
		logic            load;
		mul_op_t         op;
		logic [CH_W-1:0] rd_idx;
		logic [CH_W-1:0] chamber;
		logic            acc_clr;
		logic            acc_add;
		logic            decay_wr;
		logic            pm_wr;
		logic            commit;
		logic            adopt;
		logic            publish;
	} clr_cmd_t;

	typedef struct packed {
		logic settled;
	} clr_status_t;

	// Decay factor rounded half up to the given fraction width.
	function automatic longint decay_q(int frac, int idx);
		longint num;
		num = longint'(DECAY_HUND[idx]) * (longint'(1) << frac) + 50;
		return num / 100;
	endfunction

	// Magnitude of a coupling weight rounded half up to the given fraction width.
	function automatic longint coupling_mag(int frac, int src, int dst);
		longint t;
		longint mag;
		t = longint'(COUPLING_TENTHS[src][dst]);
		mag = (t < 0) ? -t : t;
		return (mag * (longint'(1) << frac) + 5) / 10;
	endfunction

endpackage

### hdl/clr_in_if.sv
// ---------------------------------------------------------------------------
// clr_in_if: input channel of the coupled level relaxation block
// Six starting levels and a round limit under a valid/ready handshake.
// ---------------------------------------------------------------------------
interface clr_in_if;
	logic                          valid;
	logic                          ready;
	logic [clr_pkg::LEVEL_W-1:0]   level_in_0;
	logic [clr_pkg::LEVEL_W-1:0]   level_in_1;
	logic [clr_pkg::LEVEL_W-1:0]   level_in_2;
	logic [clr_pkg::LEVEL_W-1:0]   level_in_3;
	logic [clr_pkg::LEVEL_W-1:0]   level_in_4;
	logic [clr_pkg::LEVEL_W-1:0]   level_in_5;
	logic [clr_pkg::LIMIT_W-1:0]   round_limit;

	modport source (
		output valid, level_in_0, level_in_1, level_in_2, level_in_3, level_in_4,
		       level_in_5, round_limit,
		input  ready
	);
	modport sink (
		input  valid, level_in_0, level_in_1, level_in_2, level_in_3, level_in_4,
		       level_in_5, round_limit,
		output ready
	);
endinterface

### hdl/clr_out_if.sv
// ---------------------------------------------------------------------------
// clr_out_if: result channel of the coupled level relaxation block
// Six settled levels, the round count and the settled flag.
// ---------------------------------------------------------------------------
interface clr_out_if;
	logic                          valid;
	logic                          ready;
	logic [clr_pkg::LEVEL_W-1:0]   level_out_0;
	logic [clr_pkg::LEVEL_W-1:0]   level_out_1;
	logic [clr_pkg::LEVEL_W-1:0]   level_out_2;
	logic [clr_pkg::LEVEL_W-1:0]   level_out_3;
	logic [clr_pkg::LEVEL_W-1:0]   level_out_4;
	logic [clr_pkg::LEVEL_W-1:0]   level_out_5;
	logic [clr_pkg::LIMIT_W-1:0]   rounds_run;
	logic                          settled_flag;

	modport source (
		output valid, level_out_0, level_out_1, level_out_2, level_out_3, level_out_4,
		       level_out_5, rounds_run, settled_flag,
		input  ready
	);
	modport sink (
		input  valid, level_out_0, level_out_1, level_out_2, level_out_3, level_out_4,
		       level_out_5, rounds_run, settled_flag,
		output ready
	);
endinterface

### hdl/clr_cfg_if.sv
// ---------------------------------------------------------------------------
// clr_cfg_if: configuration write channel
// Register index and write data under a valid/ready handshake.
// ---------------------------------------------------------------------------
interface clr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [clr_pkg::CFG_IDX_W-1:0]    index;
	logic [clr_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hdl/clr_datapath.sv
// ---------------------------------------------------------------------------
// clr_datapath: level storage, shared multiplier and accumulators
// Holds the configuration registers, the current and next level banks, one
// sign-magnitude multiplier with a registered product, the influence and
// change accumulators, and the result register.
// ---------------------------------------------------------------------------
module clr_datapath #(
	parameter int FRAC_BITS = clr_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  clr_pkg::clr_cmd_t                   cmd,
	output clr_pkg::clr_status_t                status,
	input  logic                                cfg_we,
	input  logic [clr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [clr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [clr_pkg::LEVEL_W-1:0]         level_in  [clr_pkg::NCH],
	output logic [clr_pkg::LEVEL_W-1:0]         level_out [clr_pkg::NCH]
);

	localparam int NCH   = clr_pkg::NCH;
	localparam int LW    = (FRAC_BITS + 1 > clr_pkg::LEVEL_W) ? FRAC_BITS + 1 : clr_pkg::LEVEL_W;
	localparam int AW    = (FRAC_BITS + 1 > clr_pkg::GAIN_W + 1) ? FRAC_BITS + 1
	                                                             : clr_pkg::GAIN_W + 1;
	localparam int BW    = LW + 2;
	localparam int PW    = AW + BW - FRAC_BITS + 1;
	localparam int ACC_W = LW + 3;
	localparam int VW    = PW + 1;
	localparam int DW    = LW + 3;
	localparam int CW    = (DW > clr_pkg::THR_W) ? DW : clr_pkg::THR_W;
	localparam int RW    = AW + 1;

	localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
	localparam logic [LW-1:0] ONE_L = LW'(1) << FRAC_BITS;
	localparam logic [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;

	logic [clr_pkg::GAIN_W-1:0]  momentum_q;
	logic [clr_pkg::THR_W-1:0]   thr_q;

	logic [LW-1:0]               lev_q [NCH];
	logic [LW-1:0]               nxt_q [NCH];
	logic [PW-1:0]               prod_q;
	logic [PW-1:0]               pm_q;
	logic [ACC_W-1:0]            acc_q;
	logic [DW-1:0]               delta_q;
	logic [clr_pkg::LEVEL_W-1:0] out_q [NCH];

	logic [AW-1:0]               decay_tab    [NCH];
	logic [AW-1:0]               coup_mag_tab [NCH][NCH];
	logic                        coup_neg_tab [NCH][NCH];

	logic [LW-1:0]               lev_rd;
	logic [RW-1:0]               rest_raw;
	logic                        rest_neg;
	logic [RW-1:0]               rest_abs;
	logic                        acc_neg;
	logic [ACC_W-1:0]            acc_abs;
	logic [AW-1:0]               mul_a;
	logic [BW-1:0]               mul_b;
	logic                        mul_neg;
	logic [AW+BW-1:0]            mul_full;
	logic [PW-2:0]               mul_mag;
	logic [PW-1:0]               prod_next;
	logic [VW-1:0]               blend;
	logic                        blend_neg;
	logic                        blend_over;
	logic [LW-1:0]               blend_clamped;
	logic [LW:0]                 diff;
	logic [LW:0]                 diff_abs;

	// Coefficient tables, fixed at elaboration.
	for (genvar gs = 0; gs < NCH; gs++) begin : g_src
		assign decay_tab[gs] = AW'(clr_pkg::decay_q(FRAC_BITS, gs));
		for (genvar gd = 0; gd < NCH; gd++) begin : g_dst
			assign coup_mag_tab[gs][gd] = AW'(clr_pkg::coupling_mag(FRAC_BITS, gs, gd));
			assign coup_neg_tab[gs][gd] = (clr_pkg::COUPLING_TENTHS[gs][gd] < 0);
		end
	end

	assign lev_rd   = lev_q[cmd.rd_idx];
	assign rest_raw = ONE_R - RW'(momentum_q);
	assign rest_neg = rest_raw[RW-1];
	assign rest_abs = rest_neg ? (~rest_raw + 1'b1) : rest_raw;
	assign acc_neg  = acc_q[ACC_W-1];
	assign acc_abs  = acc_neg ? (~acc_q + 1'b1) : acc_q;

	always_comb begin
		unique case (cmd.op)
			clr_pkg::MUL_DECAY: begin
				mul_a   = decay_tab[cmd.chamber];
				mul_b   = BW'(lev_rd);
				mul_neg = 1'b0;
			end
			clr_pkg::MUL_COUPLE: begin
				mul_a   = coup_mag_tab[cmd.rd_idx][cmd.chamber];
				mul_b   = BW'(lev_rd);
				mul_neg = coup_neg_tab[cmd.rd_idx][cmd.chamber];
			end
			clr_pkg::MUL_MOMENT: begin
				mul_a   = AW'(momentum_q);
				mul_b   = BW'(lev_rd);
				mul_neg = 1'b0;
			end
			clr_pkg::MUL_REST: begin
				mul_a   = rest_abs[AW-1:0];
				mul_b   = acc_abs[BW-1:0];
				mul_neg = rest_neg ^ acc_neg;
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				mul_neg = 1'b0;
			end
		endcase
	end

	// Magnitudes are multiplied and shifted, so the sign is applied after
	// truncation and the product rounds toward zero.
	assign mul_full  = mul_a * mul_b;
	assign mul_mag   = mul_full[AW+BW-1:FRAC_BITS];
	assign prod_next = mul_neg ? (~{1'b0, mul_mag} + 1'b1) : {1'b0, mul_mag};

	assign blend         = {pm_q[PW-1], pm_q} + {prod_q[PW-1], prod_q};
	assign blend_neg     = blend[VW-1];
	assign blend_over    = !blend_neg && (blend > ONE_V);
	assign blend_clamped = blend_neg ? '0 : (blend_over ? ONE_L : blend[LW-1:0]);
	assign diff          = {1'b0, blend_clamped} - {1'b0, lev_rd};
	assign diff_abs      = diff[LW] ? (~diff + 1'b1) : diff;

	assign status.settled = CW'(delta_q) < CW'(thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			momentum_q <= clr_pkg::MOMENTUM_RST;
			thr_q      <= clr_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			if (cfg_index == clr_pkg::CFG_IDX_MOMENTUM) begin
				momentum_q <= cfg_data[clr_pkg::GAIN_W-1:0];
			end else if (cfg_index == clr_pkg::CFG_IDX_THRESHOLD) begin
				thr_q <= cfg_data[clr_pkg::THR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_next;
		if (cmd.load) begin
			for (int k = 0; k < NCH; k++) begin
				lev_q[k] <= LW'(level_in[k]);
			end
		end else if (cmd.adopt) begin
			lev_q <= nxt_q;
		end else if (cmd.decay_wr) begin
			lev_q[cmd.chamber] <= prod_q[LW-1:0];
		end
		if (cmd.commit) begin
			nxt_q[cmd.chamber] <= blend_clamped;
		end
		if (cmd.load || cmd.adopt) begin
			delta_q <= '0;
		end else if (cmd.commit) begin
			delta_q <= delta_q + DW'(diff_abs[LW-1:0]);
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q[ACC_W-1:0];
		end
		if (cmd.pm_wr) begin
			pm_q <= prod_q;
		end
		if (cmd.publish) begin
			for (int k = 0; k < NCH; k++) begin
				out_q[k] <= lev_q[k][clr_pkg::LEVEL_W-1:0];
			end
		end
	end

	assign level_out = out_q;

endmodule

### hdl/clr_controller.sv
// ---------------------------------------------------------------------------
// clr_controller: round and chamber sequencer
// Steps each chamber through decay, six coupling products, the momentum and
// blend products and the commit, closes each round, and owns the handshakes
// and the round count and settled flag of the result.
// ---------------------------------------------------------------------------
module clr_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [clr_pkg::LIMIT_W-1:0]    round_limit,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [clr_pkg::LIMIT_W-1:0]    rounds_run,
	output logic                           settled_flag,
	output clr_pkg::clr_cmd_t              cmd,
	input  clr_pkg::clr_status_t           status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_ROUND,
		S_FINISH
	} state_t;

	localparam logic [3:0]               LAST_STEP    = 4'd9;
	localparam logic [clr_pkg::CH_W-1:0] LAST_CHAMBER = clr_pkg::CH_W'(clr_pkg::NCH - 1);

	state_t                        state_q;
	logic [3:0]                    step_q;
	logic [clr_pkg::CH_W-1:0]      chamber_q;
	logic [clr_pkg::LIMIT_W-1:0]   limit_q;
	logic [clr_pkg::LIMIT_W-1:0]   rounds_q;
	logic                          settled_q;
	logic                          out_valid_q;
	logic [clr_pkg::LIMIT_W-1:0]   rounds_out_q;
	logic                          settled_out_q;
	logic                          load;
	logic                          publish;
	logic                          run;

	assign in_ready = (state_q == S_IDLE);
	assign load     = in_valid && in_ready;
	assign publish  = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign run      = (state_q == S_RUN);

	// Step plan per chamber: decay, six coupling products, momentum product,
	// blend product, commit. Each product is consumed in the cycle after issue.
	always_comb begin
		cmd          = '0;
		cmd.load     = load;
		cmd.publish  = publish;
		cmd.adopt    = (state_q == S_ROUND);
		cmd.chamber  = chamber_q;
		cmd.rd_idx   = chamber_q;
		cmd.op       = clr_pkg::MUL_DECAY;
		if (run) begin
			unique case (step_q)
				4'd0: begin
					cmd.op      = clr_pkg::MUL_DECAY;
					cmd.acc_clr = 1'b1;
				end
				4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
					cmd.op       = clr_pkg::MUL_COUPLE;
					cmd.rd_idx   = clr_pkg::CH_W'(step_q - 4'd1);
					cmd.decay_wr = (step_q == 4'd1);
					cmd.acc_add  = (step_q != 4'd1);
				end
				4'd7: begin
					cmd.op      = clr_pkg::MUL_MOMENT;
					cmd.acc_add = 1'b1;
				end
				4'd8: begin
					cmd.op    = clr_pkg::MUL_REST;
					cmd.pm_wr = 1'b1;
				end
				4'd9: begin
					cmd.commit = 1'b1;
				end
				default: begin
					cmd.op = clr_pkg::MUL_DECAY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			chamber_q     <= '0;
			limit_q       <= '0;
			rounds_q      <= '0;
			settled_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			rounds_out_q  <= '0;
			settled_out_q <= 1'b0;
		end else begin
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load) begin
						limit_q   <= round_limit;
						rounds_q  <= '0;
						settled_q <= 1'b0;
						step_q    <= '0;
						chamber_q <= '0;
						state_q   <= (round_limit == '0) ? S_FINISH : S_RUN;
					end
				end
				S_RUN: begin
					if (step_q == LAST_STEP) begin
						step_q <= '0;
						if (chamber_q == LAST_CHAMBER) begin
							state_q <= S_ROUND;
						end else begin
							chamber_q <= chamber_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_ROUND: begin
					rounds_q  <= rounds_q + 1'b1;
					chamber_q <= '0;
					step_q    <= '0;
					if (status.settled) begin
						settled_q <= 1'b1;
						state_q   <= S_FINISH;
					end else if (rounds_q + 1'b1 == limit_q) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_FINISH: begin
					if (publish) begin
						rounds_out_q  <= rounds_q;
						settled_out_q <= settled_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign rounds_run   = rounds_out_q;
	assign settled_flag = settled_out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !in_ready)
		else $error("input accepted again before the result was published");

	a_rounds_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (rounds_q < limit_q))
		else $error("round started beyond the round limit");

	a_step_in_plan: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= LAST_STEP)
		else $error("chamber step counter out of range");

	a_publish_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		publish |-> (!out_valid_q || out_ready))
		else $error("result overwritten while still pending");

	a_settled_has_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && settled_out_q) |-> (rounds_out_q != '0))
		else $error("settled result reports no rounds");

endmodule

### hdl/coupled_level_relaxation.sv
// ---------------------------------------------------------------------------
// coupled_level_relaxation: iterative relaxation of six coupled chamber levels
// Takes six starting levels and a round limit on req, runs the relaxation
// rounds and returns the settled levels, the round count and the settled
// flag on rsp. Two configuration registers are written through cfg.
//
// Usage:
//   req  - one transaction starts one job; ready is high only while idle.
//   rsp  - one transaction per job, held in an output register until taken.
//   cfg  - always ready; index 0 is the momentum gain, index 1 the settle
//          threshold. Write only while no job is in flight.
// Sequence: every chamber steps through the single shared multiplier
//   (decay, six coupling products, momentum and blend products, commit),
//   each round ends with a round-close step, and a zero round limit goes
//   straight to the finish state; req is ready again in the cycle after
//   the result is loaded.
// Stall: a job that finishes while the previous result still waits on rsp
//   holds in its finish state until the output register is free.
// Reset: clears the handshakes and loads the momentum gain (0.7) and the
//   settle threshold (0.01) defaults.
// ---------------------------------------------------------------------------
module coupled_level_relaxation #(
	parameter int FRAC_BITS = clr_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	clr_in_if.sink     req,
	clr_out_if.source  rsp,
	clr_cfg_if.sink    cfg
);

	clr_pkg::clr_cmd_t           cmd;
	clr_pkg::clr_status_t        status;
	logic [clr_pkg::LEVEL_W-1:0] level_in  [clr_pkg::NCH];
	logic [clr_pkg::LEVEL_W-1:0] level_out [clr_pkg::NCH];

	assign level_in[0] = req.level_in_0;
	assign level_in[1] = req.level_in_1;
	assign level_in[2] = req.level_in_2;
	assign level_in[3] = req.level_in_3;
	assign level_in[4] = req.level_in_4;
	assign level_in[5] = req.level_in_5;

	assign cfg.ready = 1'b1;

	clr_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.round_limit  (req.round_limit),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.rounds_run   (rsp.rounds_run),
		.settled_flag (rsp.settled_flag),
		.cmd          (cmd),
		.status       (status)
	);

	clr_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.level_in  (level_in),
		.level_out (level_out)
	);

	assign rsp.level_out_0 = level_out[0];
	assign rsp.level_out_1 = level_out[1];
	assign rsp.level_out_2 = level_out[2];
	assign rsp.level_out_3 = level_out[3];
	assign rsp.level_out_4 = level_out[4];
	assign rsp.level_out_5 = level_out[5];

endmodule

### dv/coupled_level_relaxation_tb.sv
// ---------------------------------------------------------------------------
// coupled_level_relaxation_tb: self-checking bench for the relaxation block
// Drives start levels and round limits under several momentum and threshold
// settings, predicts every round of the relaxation in the bench, and compares
// each returned level set, round count and settled flag in order.
// ---------------------------------------------------------------------------
module coupled_level_relaxation_tb;

	localparam int     FRAC      = clr_pkg::FRAC_BITS_DEF;
	localparam longint ONE       = longint'(1) << FRAC;
	localparam int     IDLE_MAX  = 80000;
	localparam int     PHASE_LEN = 92;
	localparam int     LVW       = clr_pkg::LEVEL_W;
	localparam int     LMW       = clr_pkg::LIMIT_W;

	// Coupling in tenths, [source][target], and decay in hundredths.
	localparam int LINK_TENTHS [6][6] = '{
		'{ 0, -3,  6,  4, -2,  3},
		'{-3,  0, -6, -5,  3,  4},
		'{ 3, -4,  0,  2, -3,  2},
		'{ 5, -7,  3,  0, -4,  5},
		'{-2,  2, -2, -3,  0,  2},
		'{ 3,  2,  2,  3,  1,  0}
	};
	localparam int FADE_HUND [6] = '{90, 93, 85, 97, 88, 94};

	typedef struct packed {
		logic [5:0][LVW-1:0] level;
		logic [LMW-1:0]      limit;
	} job_t;

	typedef struct packed {
		logic [5:0][LVW-1:0] level;
		logic [LMW-1:0]      rounds;
		logic                settled;
	} outcome_t;

	class relax_scoreboard;
		longint unsigned momentum  = longint'(clr_pkg::MOMENTUM_RST);
		longint unsigned threshold = longint'(clr_pkg::THRESHOLD_RST);
		outcome_t        outcome_q[$];
		int unsigned     errors;

		function void write_reg(logic [clr_pkg::CFG_IDX_W-1:0] idx,
			logic [clr_pkg::CFG_DATA_W-1:0] data);
			if (idx == clr_pkg::CFG_IDX_MOMENTUM)
				momentum = longint'(data[clr_pkg::GAIN_W-1:0]);
			else if (idx == clr_pkg::CFG_IDX_THRESHOLD)
				threshold = longint'(data[clr_pkg::THR_W-1:0]);
		endfunction

		// Fixed-point product, truncated toward zero.
		function longint fx_mul(longint a, longint b);
			longint p;
			p = (((a < 0) ? -a : a) * ((b < 0) ? -b : b)) >> FRAC;
			return ((a < 0) != (b < 0)) ? -p : p;
		endfunction

		function outcome_t relax(job_t j);
			longint   lvl[6];
			longint   nxt[6];
			longint   rest, infl, v, delta, w, mag;
			int       rounds;
			bit       done;
			outcome_t r;
			rest = ONE - longint'(momentum);
			for (int i = 0; i < 6; i++)
				lvl[i] = longint'(j.level[i]);
			rounds = 0;
			done = 0;
			while (rounds < int'(j.limit) && !done) begin
				delta = 0;
				for (int i = 0; i < 6; i++) begin
					lvl[i] = fx_mul(lvl[i], (longint'(FADE_HUND[i]) * ONE + 50) / 100);
					infl = 0;
					for (int k = 0; k < 6; k++) begin
						mag = longint'(LINK_TENTHS[k][i]);
						mag = (mag < 0) ? -mag : mag;
						w = (mag * ONE + 5) / 10;
						if (LINK_TENTHS[k][i] < 0)
							w = -w;
						infl += fx_mul(w, lvl[k]);
					end
					v = fx_mul(longint'(momentum), lvl[i]) + fx_mul(rest, infl);
					if (v < 0)
						v = 0;
					if (v > ONE)
						v = ONE;
					nxt[i] = v;
					delta += (v > lvl[i]) ? v - lvl[i] : lvl[i] - v;
				end
				lvl = nxt;
				rounds++;
				if (delta < longint'(threshold))
					done = 1;
			end
			for (int i = 0; i < 6; i++)
				r.level[i] = lvl[i][LVW-1:0];
			r.rounds = rounds[LMW-1:0];
			r.settled = done;
			return r;
		endfunction

		function void note_job(job_t j);
			outcome_q.push_back(relax(j));
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (outcome_q.size() == 0) begin
				errors++;
				$error("result transaction with no job outstanding: rounds_run %0d", got.rounds);
				return;
			end
			want = outcome_q.pop_front();
			for (int i = 0; i < 6; i++) begin
				if (got.level[i] !== want.level[i]) begin
					errors++;
					$error("level_out_%0d: expected %0d, actual %0d", i, want.level[i],
						got.level[i]);
				end
			end
			if (got.rounds !== want.rounds) begin
				errors++;
				$error("rounds_run: expected %0d, actual %0d", want.rounds, got.rounds);
			end
			if (got.settled !== want.settled) begin
				errors++;
				$error("settled_flag: expected %0d, actual %0d", want.settled, got.settled);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;

	relax_scoreboard sb = new();

	clr_in_if  req_if ();
	clr_out_if rsp_if ();
	clr_cfg_if cfg_if ();

	coupled_level_relaxation u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	always #1 clk = ~clk;

	// Result side: check every accepted transaction, stall at random.
	initial begin
		outcome_t got;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got.level = {rsp_if.level_out_5, rsp_if.level_out_4, rsp_if.level_out_3,
					rsp_if.level_out_2, rsp_if.level_out_1, rsp_if.level_out_0};
				got.rounds = rsp_if.rounds_run;
				got.settled = rsp_if.settled_flag;
				sb.check_result(got);
			end
			rsp_if.ready <= calm || ($urandom_range(99) >= 8);
		end
	end

	// Ends the run if no channel moves a transaction for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_MAX) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
			    (cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("coupled_level_relaxation regression: fail");
		$finish;
	end

	task automatic push_job(job_t j);
		if (!calm && $urandom_range(99) < 8) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 70)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.level_in_0 <= j.level[0];
		req_if.level_in_1 <= j.level[1];
		req_if.level_in_2 <= j.level[2];
		req_if.level_in_3 <= j.level[3];
		req_if.level_in_4 <= j.level[4];
		req_if.level_in_5 <= j.level[5];
		req_if.round_limit <= j.limit;
		do @(posedge clk); while (!req_if.ready);
		sb.note_job(j);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (sb.outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// Leaves valid raised so that writes can follow back to back; the caller
	// drops it after the last write.
	task automatic write_reg(logic [clr_pkg::CFG_IDX_W-1:0] idx,
		logic [clr_pkg::CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, data);
	endtask

	function automatic job_t uniform_job(logic [LVW-1:0] lvl, logic [LMW-1:0] lim);
		job_t j;
		for (int i = 0; i < 6; i++)
			j.level[i] = lvl;
		j.limit = lim;
		return j;
	endfunction

	// Mostly in-range levels and short limits; a few long runs and overranged levels.
	function automatic job_t random_job();
		job_t        j;
		int unsigned pick;
		for (int i = 0; i < 6; i++) begin
			pick = $urandom_range(99);
			if (pick < 75)
				j.level[i] = LVW'($urandom_range(0, 32'(ONE)));
			else if (pick < 82)
				j.level[i] = '0;
			else if (pick < 89)
				j.level[i] = LVW'(ONE);
			else
				j.level[i] = LVW'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 85)
			j.limit = LMW'($urandom_range(0, 12));
		else if (pick < 97)
			j.limit = LMW'($urandom_range(13, 64));
		else
			j.limit = LMW'($urandom_range(65, 255));
		return j;
	endfunction

	initial begin
		job_t         j;
		longint       moment_set [8];
		longint       thresh_set [8];
		req_if.valid <= 1'b0;
		req_if.level_in_0 <= '0;
		req_if.level_in_1 <= '0;
		req_if.level_in_2 <= '0;
		req_if.level_in_3 <= '0;
		req_if.level_in_4 <= '0;
		req_if.level_in_5 <= '0;
		req_if.round_limit <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= clr_pkg::CFG_IDX_MOMENTUM;
		cfg_if.data <= '0;
		arst_n <= 1'b0;
		calm = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed jobs under the reset settings.
		push_job(uniform_job(16'd0, 8'd0));
		push_job(uniform_job(16'hFFFF, 8'd0));
		push_job(uniform_job(16'd32768, 8'd1));
		push_job(uniform_job(16'd32768, 8'd255));
		push_job(uniform_job(16'd0, 8'd1));
		push_job(uniform_job(16'd0, 8'd255));
		push_job(uniform_job(16'hFFFF, 8'd1));
		push_job(uniform_job(16'hFFFF, 8'd4));
		for (int c = 0; c < 6; c++) begin
			j = uniform_job(16'd0, 8'd8);
			j.level[c] = 16'd32768;
			push_job(j);
		end
		push_job(uniform_job(16'hAAAA, 8'h55));
		push_job(uniform_job(16'h5555, 8'hAA));
		j = random_job();
		j.limit = 8'd255;
		push_job(j);
		j = random_job();
		j.limit = 8'd3;
		push_job(j);

		// Register settings per phase, the extremes among them.
		moment_set = '{22938, 0, 32768, 65535, 16384, 40000, 0, 22938};
		thresh_set = '{328, 328, 0, 1000, 196608, 262143, 0, 328};
		moment_set[6] = longint'($urandom_range(0, 32'(ONE)));
		thresh_set[6] = longint'($urandom_range(0, 4000));
		for (int p = 0; p < 8; p++) begin
			drain();
			write_reg(clr_pkg::CFG_IDX_MOMENTUM, clr_pkg::CFG_DATA_W'(moment_set[p]));
			write_reg(clr_pkg::CFG_IDX_THRESHOLD, clr_pkg::CFG_DATA_W'(thresh_set[p]));
			cfg_if.valid <= 1'b0;
			calm = (p == 3);
			for (int n = 0; n < PHASE_LEN; n++)
				push_job(random_job());
		end
		calm = 0;

		drain();
		repeat (70) @(posedge clk);
		if (sb.errors == 0 && sb.outcome_q.size() == 0)
			$display("coupled_level_relaxation regression: pass");
		else
			$display("coupled_level_relaxation regression: fail");
		$finish;
	end

endmodule

### filelist.f
hdl/clr_pkg.sv
hdl/clr_in_if.sv
hdl/clr_out_if.sv
hdl/clr_cfg_if.sv
hdl/clr_datapath.sv
hdl/clr_controller.sv
hdl/coupled_level_relaxation.sv
dv/coupled_level_relaxation_tb.sv
